/* rtl/core/resp_request_parser_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef RESP_REQUEST_PARSER_MACROS_SVH
`define RESP_REQUEST_PARSER_MACROS_SVH

// Checked only out of reset.
`define RRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rrp_pkg.sv */
// Shared types and constants of the RESP request parser.
package rrp_pkg;

  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int LENGTH_WIDTH_DEF = 30;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int ACC_W            = 31;

  localparam logic [15:0] MAX_ARGS_RST    = 16'd1024;
  localparam logic [29:0] MAX_ARG_LEN_RST = 30'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_ARG_DONE = 3'd2;
  localparam logic [2:0] EV_REQ_DONE = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MARKER    = 3'd1;
  localparam logic [2:0] ERR_DIGIT     = 3'd2;
  localparam logic [2:0] ERR_LF        = 3'd3;
  localparam logic [2:0] ERR_COUNT     = 3'd4;
  localparam logic [2:0] ERR_LENGTH    = 3'd5;
  localparam logic [2:0] ERR_TERMINATE = 3'd6;

  localparam logic CFG_REG_MAX_ARGS    = 1'b0;
  localparam logic CFG_REG_MAX_ARG_LEN = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] arg_index;
    logic [2:0]  error_code;
  } out_word_t;

  typedef struct packed {
    logic [15:0] max_args;
    logic [29:0] max_arg_len;
  } cfg_limits_t;

endpackage

/* rtl/core/rrp_cfg_regs.sv */
// APB-style limit registers of the parser.
module rrp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rrp_pkg::cfg_limits_t           limits
);

  logic [15:0] max_args_r;
  logic [29:0] max_arg_len_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r    <= rrp_pkg::MAX_ARGS_RST;
      max_arg_len_r <= rrp_pkg::MAX_ARG_LEN_RST;
    end else if (wr_en) begin
      if (paddr[2] == rrp_pkg::CFG_REG_MAX_ARGS) begin
        max_args_r <= pwdata[15:0];
      end else begin
        max_arg_len_r <= pwdata[29:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rrp_pkg::CFG_REG_MAX_ARGS) begin
      prdata = {16'b0, max_args_r};
    end else begin
      prdata = {2'b0, max_arg_len_r};
    end
  end

  assign limits.max_args    = max_args_r;
  assign limits.max_arg_len = max_arg_len_r;

endmodule

/* rtl/core/rrp_num.sv */
// Decimal digit accumulate with saturation and limit compare.
module rrp_num (
  input  logic [rrp_pkg::ACC_W-1:0] acc,
  input  logic [7:0]                data_byte,
  input  logic [31:0]               limit,
  output logic                      is_digit,
  output logic [rrp_pkg::ACC_W-1:0] acc_next,
  output logic                      over_limit
);

  logic [3:0]                  digit;
  logic [rrp_pkg::ACC_W+3:0]   prod;

  assign is_digit = (data_byte >= rrp_pkg::CH_ZERO) && (data_byte <= rrp_pkg::CH_NINE);
  assign digit    = data_byte[3:0];

  // acc*10 + digit as two shifts and two adds
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{rrp_pkg::ACC_W{1'b0}}, digit};

  always_comb begin
    if (prod[rrp_pkg::ACC_W+3:rrp_pkg::ACC_W] != 4'd0) begin
      acc_next = {rrp_pkg::ACC_W{1'b1}};
    end else begin
      acc_next = prod[rrp_pkg::ACC_W-1:0];
    end
  end

  assign over_limit = {1'b0, acc} > limit;

endmodule

/* rtl/core/rrp_parse.sv */
// Parse state and next-state logic for one stream byte.
module rrp_parse #(
  parameter int COUNT_WIDTH  = rrp_pkg::COUNT_WIDTH_DEF,
  parameter int LENGTH_WIDTH = rrp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  rrp_pkg::in_word_t    in_word,
  input  rrp_pkg::cfg_limits_t limits,
  output rrp_pkg::out_word_t   result
);

  typedef enum logic [3:0] {
    PH_STAR, PH_CNT_BEG, PH_CNT_SGN, PH_CNT_DIG, PH_CNT_LF,
    PH_DOLLAR, PH_LEN_BEG, PH_LEN_SGN, PH_LEN_DIG, PH_LEN_LF,
    PH_PAYLOAD, PH_PAY_CR, PH_PAY_LF
  } phase_t;

  localparam logic [31:0] CNT_MASK = 32'((33'd1 << COUNT_WIDTH) - 33'd1);
  localparam logic [31:0] LEN_MASK = 32'((33'd1 << LENGTH_WIDTH) - 33'd1);

  phase_t                    phase_r, phase_nxt, ph;
  logic [rrp_pkg::ACC_W-1:0] acc_r, acc_nxt, acc;
  logic                      neg_r, neg_nxt, neg;
  logic [COUNT_WIDTH-1:0]    total_r, total_nxt, total;
  logic [COUNT_WIDTH-1:0]    done_r, done_nxt, done, done_inc;
  logic [LENGTH_WIDTH-1:0]   left_r, left_nxt, left, left_dec;
  logic [2:0]                latch_r, latch_nxt, latch;

  logic [7:0]  b;
  logic [31:0] cnt_lim, len_lim, num_lim;
  logic [31:0] done_ext;
  logic        is_len;
  logic        num_digit, num_over;
  logic [rrp_pkg::ACC_W-1:0] num_acc;
  logic [2:0]  ev, err;
  logic [7:0]  pay;

  assign b = in_word.data_byte;

  // restart clears the state ahead of this byte
  always_comb begin
    if (in_word.restart) begin
      ph    = PH_STAR;
      acc   = '0;
      neg   = 1'b0;
      total = '0;
      done  = '0;
      left  = '0;
      latch = rrp_pkg::ERR_NONE;
    end else begin
      ph    = phase_r;
      acc   = acc_r;
      neg   = neg_r;
      total = total_r;
      done  = done_r;
      left  = left_r;
      latch = latch_r;
    end
  end

  assign cnt_lim  = ({16'b0, limits.max_args} < CNT_MASK) ? {16'b0, limits.max_args} : CNT_MASK;
  assign len_lim  = ({2'b0, limits.max_arg_len} < LEN_MASK) ? {2'b0, limits.max_arg_len}
                                                             : LEN_MASK;
  assign is_len   = ph inside {PH_LEN_BEG, PH_LEN_SGN, PH_LEN_DIG};
  assign num_lim  = is_len ? len_lim : cnt_lim;
  assign done_ext = 32'(done);
  assign done_inc = done + COUNT_WIDTH'(1);
  assign left_dec = (left == '0) ? '0 : left - LENGTH_WIDTH'(1);

  rrp_num u_num (
    .acc        (acc),
    .data_byte  (b),
    .limit      (num_lim),
    .is_digit   (num_digit),
    .acc_next   (num_acc),
    .over_limit (num_over)
  );

  always_comb begin
    phase_nxt = ph;
    acc_nxt   = acc;
    neg_nxt   = neg;
    total_nxt = total;
    done_nxt  = done;
    left_nxt  = left;
    latch_nxt = latch;
    ev        = rrp_pkg::EV_CONSUMED;
    pay       = 8'd0;
    err       = rrp_pkg::ERR_NONE;
    if (latch == rrp_pkg::ERR_NONE) begin
      case (ph)
        PH_STAR, PH_DOLLAR: begin
          if ((ph == PH_STAR && b == rrp_pkg::CH_STAR) ||
              (ph == PH_DOLLAR && b == rrp_pkg::CH_DOLLAR)) begin
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            phase_nxt = (ph == PH_STAR) ? PH_CNT_BEG : PH_LEN_BEG;
          end else begin
            err = rrp_pkg::ERR_MARKER;
          end
        end
        PH_CNT_BEG, PH_CNT_SGN, PH_CNT_DIG, PH_LEN_BEG, PH_LEN_SGN, PH_LEN_DIG: begin
          if ((ph == PH_CNT_BEG || ph == PH_LEN_BEG) && b == rrp_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = is_len ? PH_LEN_SGN : PH_CNT_SGN;
          end else if (num_digit) begin
            acc_nxt   = num_acc;
            phase_nxt = is_len ? PH_LEN_DIG : PH_CNT_DIG;
          end else if ((ph == PH_CNT_DIG || ph == PH_LEN_DIG) && b == rrp_pkg::CH_CR) begin
            if (neg || num_over) begin
              err = is_len ? rrp_pkg::ERR_LENGTH : rrp_pkg::ERR_COUNT;
            end else begin
              phase_nxt = is_len ? PH_LEN_LF : PH_CNT_LF;
            end
          end else begin
            err = rrp_pkg::ERR_DIGIT;
          end
        end
        PH_CNT_LF: begin
          if (b != rrp_pkg::CH_LF) begin
            err = rrp_pkg::ERR_LF;
          end else begin
            total_nxt = COUNT_WIDTH'(acc);
            done_nxt  = '0;
            if (COUNT_WIDTH'(acc) == '0) begin
              ev        = rrp_pkg::EV_REQ_DONE;
              phase_nxt = PH_STAR;
            end else begin
              phase_nxt = PH_DOLLAR;
            end
          end
        end
        PH_LEN_LF: begin
          if (b != rrp_pkg::CH_LF) begin
            err = rrp_pkg::ERR_LF;
          end else begin
            left_nxt  = LENGTH_WIDTH'(acc);
            phase_nxt = (LENGTH_WIDTH'(acc) == '0) ? PH_PAY_CR : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          ev       = rrp_pkg::EV_PAYLOAD;
          pay      = b;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_PAY_CR;
          end
        end
        PH_PAY_CR: begin
          if (b == rrp_pkg::CH_CR) begin
            phase_nxt = PH_PAY_LF;
          end else begin
            err = rrp_pkg::ERR_TERMINATE;
          end
        end
        PH_PAY_LF: begin
          if (b != rrp_pkg::CH_LF) begin
            err = rrp_pkg::ERR_TERMINATE;
          end else if (done_inc == total) begin
            ev        = rrp_pkg::EV_REQ_DONE;
            done_nxt  = '0;
            total_nxt = '0;
            phase_nxt = PH_STAR;
          end else begin
            ev        = rrp_pkg::EV_ARG_DONE;
            done_nxt  = done_inc;
            phase_nxt = PH_DOLLAR;
          end
        end
        default: begin
          phase_nxt = PH_STAR;
          err       = rrp_pkg::ERR_MARKER;
        end
      endcase
      if (err != rrp_pkg::ERR_NONE) begin
        latch_nxt = err;
      end
    end

    result.arg_index = done_ext[15:0];
    if (latch_nxt != rrp_pkg::ERR_NONE) begin
      result.event_res    = rrp_pkg::EV_ERROR;
      result.payload_byte = 8'd0;
      result.error_code   = latch_nxt;
    end else begin
      result.event_res    = ev;
      result.payload_byte = pay;
      result.error_code   = rrp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STAR;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      total_r <= '0;
      done_r  <= '0;
      left_r  <= '0;
      latch_r <= rrp_pkg::ERR_NONE;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      left_r  <= left_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

/* rtl/core/resp_request_parser.sv */
// Top level of the RESP multi-bulk request parser.
//
// Input channel in_*: one stream byte per word plus a restart flag that
// clears the parse state ahead of that byte. Output channel out_*: exactly
// one event word per input word (consumed, payload byte, argument done,
// request done or error with its code and the current argument index).
// A word moves when valid is high and stall is low.
// The byte is parsed in the accepting cycle and the event sits in the
// output register from the next cycle on.
// Throughput is one byte per cycle while in_stall is low; the parse state
// loop closes through compares, a times-ten add and a decrement.
// While the receiver stalls, the output word holds and the input is
// stalled only as long as that word is still waiting.
// Reset (rst_n low, synchronous) empties the output register, clears the
// parse state and loads the limit registers: max_args 1024 at address 0,
// max_arg_len 2^29 at address 4. The user writes limits over the APB port
// only while the parser is idle; the block itself has no check for this.
// An error sticks and repeats on every byte until a restart word.
`include "resp_request_parser_macros.svh"

module resp_request_parser #(
  parameter int COUNT_WIDTH  = rrp_pkg::COUNT_WIDTH_DEF,
  parameter int LENGTH_WIDTH = rrp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rrp_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rrp_pkg::out_word_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  rrp_pkg::cfg_limits_t limits;
  rrp_pkg::out_word_t   result;
  rrp_pkg::out_word_t   out_data_r;
  logic                 out_valid_r;
  logic                 accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  rrp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  rrp_parse #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .limits  (limits),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRP_ASSERT(a_accept_fills, (in_valid && !in_stall) |=> out_valid_r, "accepted byte lost")
  `RRP_ASSERT(a_err_code, (out_valid_r && out_data_r.event_res == rrp_pkg::EV_ERROR) |-> (out_data_r.error_code != rrp_pkg::ERR_NONE && out_data_r.payload_byte == 8'd0), "error event without code")
  `RRP_ASSERT(a_ok_no_code, (out_valid_r && out_data_r.event_res != rrp_pkg::EV_ERROR) |-> (out_data_r.error_code == rrp_pkg::ERR_NONE), "code on non-error event")
  `RRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
